[src/stereo_ping_pong_delay_defines.svh]
// Assertion macros for the stereo ping-pong delay checker.
`ifndef STEREO_PING_PONG_DELAY_DEFINES_SVH
`define STEREO_PING_PONG_DELAY_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SPPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define SPPD_ASSERT_RESET(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[src/sppd_pkg.sv]
// Types, constants and arithmetic helpers of the stereo ping-pong delay.
package sppd_pkg;

  localparam int unsigned LINE_DEPTH = 65536;
  localparam int unsigned PTR_W      = $clog2(LINE_DEPTH);
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FB_W       = 16;
  localparam int unsigned GAIN_SHIFT = 15;
  localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned SUM_W      = SAMPLE_W + 3;
  localparam int unsigned CMP_W      = ((PTR_W > DELAY_W) ? PTR_W : DELAY_W) + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SEND    = CFG_IDX_W'(1);

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(12000);
  localparam logic [GAIN_W-1:0]  SEND_RESET  = '0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  localparam logic signed [FB_W-1:0] FEEDBACK_Q15 = FB_W'(11796);
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam prod_t   ROUND_HALF = prod_t'(1 << (GAIN_SHIFT - 1));

  // Clamp a widened sum to the signed sample range.
  function automatic sample_t sat_sample(input sum_t x);
    sample_t res;
    if (x > sum_t'(SAMPLE_MAX)) begin
      res = SAMPLE_MAX;
    end else if (x < sum_t'(SAMPLE_MIN)) begin
      res = SAMPLE_MIN;
    end else begin
      res = x[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // Scale a Q.15 product back, round to nearest with ties toward plus infinity.
  function automatic sum_t rnd_q15(input prod_t p);
    prod_t r;
    r = p + ROUND_HALF;
    return sum_t'(r >>> GAIN_SHIFT);
  endfunction

endpackage

[src/sppd_intf.sv]
// Valid/ready channel interfaces for the stereo ping-pong delay.
interface sppd_in_if;
  logic              valid;
  logic              ready;
  sppd_pkg::sample_t dry_left;
  sppd_pkg::sample_t dry_right;
  sppd_pkg::sample_t send_left;
  sppd_pkg::sample_t send_right;

  modport source (
    output valid, output dry_left, output dry_right,
    output send_left, output send_right, input ready
  );
  modport sink (
    input valid, input dry_left, input dry_right,
    input send_left, input send_right, output ready
  );
endinterface

interface sppd_out_if;
  logic              valid;
  logic              ready;
  sppd_pkg::sample_t out_left;
  sppd_pkg::sample_t out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

[src/sppd_ram.sv]
// Generic simple dual-port RAM with a registered read, read-before-write.
module sppd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/stereo_ping_pong_delay.sv]
// Stereo ping-pong delay: two cross-fed delay lines in block RAM.
//
// The block accepts one stereo transaction per clock cycle while the output is not stalled,
// limited by the single read port and single write port of each line RAM. A transaction
// reads both lines at the edge where it is accepted. In the compute stage it computes the
// cross-fed write-back: feedback multiply, rounding, three-term sum and saturation. It
// writes both lines and loads the output register together when that stage advances. A
// delay of one sample is served from a last-write register. The lines need no clearing
// pass after reset: the write pointer and a wrap flag track which entries were written,
// and an entry not yet written reads as zero. A stalled output holds one result in the
// output register and one transaction in the compute stage. After that, the input is held
// off until the output is taken.
module stereo_ping_pong_delay (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sppd_in_if.sink                          in_i,
  sppd_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [sppd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sppd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [sppd_pkg::DELAY_W-1:0] delay_q;
  logic [sppd_pkg::GAIN_W-1:0]  send_q;

  logic [sppd_pkg::PTR_W-1:0] wp_q, wp_d;
  logic                       full_q, full_d;

  logic [sppd_pkg::CMP_W-1:0] d_raw, d_clip;
  logic [sppd_pkg::PTR_W-1:0] d_eff;
  logic [sppd_pkg::PTR_W:0]   rd_diff;
  logic [sppd_pkg::PTR_W-1:0] rd_addr;
  logic                       rd_wrap;
  logic                       accept;

  sppd_pkg::prod_t ds_l, ds_r;

  logic                       b_valid_q;
  logic                       b_adv;
  logic [sppd_pkg::PTR_W-1:0] b_wp_q, b_rd_q;
  logic                       b_rd_ok_q;
  sppd_pkg::sample_t          b_dry_l_q, b_dry_r_q, b_send_l_q, b_send_r_q;
  sppd_pkg::prod_t            b_ds_l_q, b_ds_r_q;

  sppd_pkg::sample_t ram_l_q, ram_r_q;
  sppd_pkg::sample_t wet_l, wet_r;
  sppd_pkg::prod_t   fbp_l, fbp_r;
  sppd_pkg::sample_t to_left, to_right;
  sppd_pkg::sample_t res_l, res_r;
  logic              fwd_hit;

  logic                       l_valid_q;
  logic [sppd_pkg::PTR_W-1:0] l_addr_q;
  sppd_pkg::sample_t          l_left_q, l_right_q;

  logic              out_valid_q;
  sppd_pkg::sample_t out_left_q, out_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= sppd_pkg::DELAY_RESET;
      send_q  <= sppd_pkg::SEND_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sppd_pkg::REG_DELAY_SAMPLES: delay_q <= cfg_data_i[sppd_pkg::DELAY_W-1:0];
        sppd_pkg::REG_DELAY_SEND:    send_q  <= cfg_data_i[sppd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = in_i.valid && in_i.ready;
  assign b_adv      = b_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !b_valid_q || b_adv;

  always_comb begin
    d_raw = sppd_pkg::CMP_W'(delay_q);
    if (d_raw == '0) begin
      d_clip = sppd_pkg::CMP_W'(1);
    end else if (d_raw > sppd_pkg::CMP_W'(sppd_pkg::LINE_DEPTH - 1)) begin
      d_clip = sppd_pkg::CMP_W'(sppd_pkg::LINE_DEPTH - 1);
    end else begin
      d_clip = d_raw;
    end
    d_eff   = d_clip[sppd_pkg::PTR_W-1:0];
    rd_wrap = wp_q < d_eff;
    if (rd_wrap) begin
      rd_diff = {1'b0, wp_q} + (sppd_pkg::PTR_W+1)'(sppd_pkg::LINE_DEPTH) - {1'b0, d_eff};
    end else begin
      rd_diff = {1'b0, wp_q} - {1'b0, d_eff};
    end
    rd_addr = rd_diff[sppd_pkg::PTR_W-1:0];
  end

  always_comb begin
    wp_d   = wp_q;
    full_d = full_q;
    if (accept) begin
      if (wp_q == sppd_pkg::PTR_W'(sppd_pkg::LINE_DEPTH - 1)) begin
        wp_d   = '0;
        full_d = 1'b1;
      end else begin
        wp_d = wp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      full_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      full_q <= full_d;
    end
  end

  assign ds_l = in_i.dry_left  * $signed({1'b0, send_q});
  assign ds_r = in_i.dry_right * $signed({1'b0, send_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (accept) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_wp_q     <= wp_q;
      b_rd_q     <= rd_addr;
      b_rd_ok_q  <= full_q || !rd_wrap;
      b_dry_l_q  <= in_i.dry_left;
      b_dry_r_q  <= in_i.dry_right;
      b_send_l_q <= in_i.send_left;
      b_send_r_q <= in_i.send_right;
      b_ds_l_q   <= ds_l;
      b_ds_r_q   <= ds_r;
    end
  end

  sppd_ram #(
    .WIDTH (sppd_pkg::SAMPLE_W),
    .DEPTH (sppd_pkg::LINE_DEPTH)
  ) u_left_line (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (b_wp_q),
    .wdata_i (to_left),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_l_q)
  );

  sppd_ram #(
    .WIDTH (sppd_pkg::SAMPLE_W),
    .DEPTH (sppd_pkg::LINE_DEPTH)
  ) u_right_line (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (b_wp_q),
    .wdata_i (to_right),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_r_q)
  );

  // Forward the write that landed on the same edge as this transaction's read.
  always_comb begin
    fwd_hit = l_valid_q && (l_addr_q == b_rd_q);
    if (fwd_hit) begin
      wet_l = l_left_q;
      wet_r = l_right_q;
    end else if (b_rd_ok_q) begin
      wet_l = ram_l_q;
      wet_r = ram_r_q;
    end else begin
      wet_l = '0;
      wet_r = '0;
    end
    fbp_l    = wet_l * sppd_pkg::FEEDBACK_Q15;
    fbp_r    = wet_r * sppd_pkg::FEEDBACK_Q15;
    to_left  = sppd_pkg::sat_sample(sppd_pkg::sum_t'(b_send_r_q)
                                    + sppd_pkg::rnd_q15(b_ds_r_q)
                                    + sppd_pkg::rnd_q15(fbp_r));
    to_right = sppd_pkg::sat_sample(sppd_pkg::sum_t'(b_send_l_q)
                                    + sppd_pkg::rnd_q15(b_ds_l_q)
                                    + sppd_pkg::rnd_q15(fbp_l));
    res_l    = sppd_pkg::sat_sample(sppd_pkg::sum_t'(b_dry_l_q) + sppd_pkg::sum_t'(wet_l));
    res_r    = sppd_pkg::sat_sample(sppd_pkg::sum_t'(b_dry_r_q) + sppd_pkg::sum_t'(wet_r));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
    end else if (b_adv) begin
      l_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      l_addr_q  <= b_wp_q;
      l_left_q  <= to_left;
      l_right_q <= to_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_left_q  <= res_l;
      out_right_q <= res_r;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;

endmodule

[src/sppd_checker.sv]
// Port-level assertion checker for the stereo ping-pong delay, bound to the top level.
`include "stereo_ping_pong_delay_defines.svh"

module sppd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input sppd_pkg::sample_t out_left_i,
  input sppd_pkg::sample_t out_right_i
);

  `SPPD_ASSERT(a_out_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `SPPD_ASSERT(a_out_data_hold, out_valid_i && !out_ready_i |=> $stable(out_left_i) && $stable(out_right_i), "stalled result changed")
  `SPPD_ASSERT(a_in_stall_cause, !in_ready_i |-> out_valid_i && !out_ready_i, "input held off without a stalled result")
  `SPPD_ASSERT(a_in_to_out, in_valid_i && in_ready_i |-> ##2 out_valid_i, "accepted transaction produced no result")
  `SPPD_ASSERT_RESET(a_reset_idle, !rst_ni |-> !out_valid_i && in_ready_i, "block not idle in reset")

endmodule

bind stereo_ping_pong_delay sppd_checker u_sppd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.out_left),
  .out_right_i (out_o.out_right)
);
